@@ rtl/request_line_path_decoder_macros.svh @@
// Assertion macros shared by the request line path decoder modules.
`ifndef REQUEST_LINE_PATH_DECODER_MACROS_SVH
`define REQUEST_LINE_PATH_DECODER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RLPD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define RLPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rlpd_pkg.sv @@
// Shared types, codes and character tables of the request line path decoder.
`timescale 1ns / 1ps

package rlpd_pkg;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_METHOD = 2'd1;
    localparam logic [1:0] ST_NO_SPACE   = 2'd2;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_SLASH   = 8'h2F;

    localparam logic [3:0] INDEX_TAIL_LEN = 4'd10;

    // One entry per accepted request byte that causes results: up to three
    // literal path bytes, then optionally the index tail, then optionally
    // the status item.
    typedef struct packed {
        logic [1:0]      n_bytes;
        logic [2:0][7:0] bytes;
        logic            index_tail;
        logic            status_en;
        logic [1:0]      status;
        logic            hd;
    } rlpd_cmd_t;

    function automatic logic [7:0] get_char(input logic [1:0] pos);
        logic [7:0] c;
        unique case (pos)
            2'd0:    c = 8'h47;
            2'd1:    c = 8'h45;
            2'd2:    c = 8'h54;
            default: c = CH_SPACE;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] head_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = 8'h48;
            3'd1:    c = 8'h45;
            3'd2:    c = 8'h41;
            3'd3:    c = 8'h44;
            3'd4:    c = CH_SPACE;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] index_char(input logic [3:0] i);
        logic [7:0] c;
        unique case (i)
            4'd0:    c = 8'h69;
            4'd1:    c = 8'h6E;
            4'd2:    c = 8'h64;
            4'd3:    c = 8'h65;
            4'd4:    c = 8'h78;
            4'd5:    c = 8'h2E;
            4'd6:    c = 8'h68;
            4'd7:    c = 8'h74;
            4'd8:    c = 8'h6D;
            4'd9:    c = 8'h6C;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46)
            || (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] u;
        logic [7:0] d;
        u = (c >= 8'h61) ? c - 8'h20 : c;
        d = (u >= 8'h41) ? u - 8'h37 : u - 8'h30;
        return d[3:0];
    endfunction

endpackage

@@ rtl/rlpd_front.sv @@
// Front part: method matching, path percent decoding and result classification.
`timescale 1ns / 1ps

module rlpd_front
    import rlpd_pkg::*;
#(
    parameter int MAX_PATH_LEN = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       in_end,
    output logic       push,
    output rlpd_cmd_t  cmd
);

    localparam int RAW_W = $clog2(MAX_PATH_LEN);
    localparam logic [RAW_W-1:0] RAW_LIMIT = RAW_W'(MAX_PATH_LEN - 1);

    localparam logic [1:0] PH_METHOD = 2'd0;
    localparam logic [1:0] PH_PATH   = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    logic [1:0]       phase_reg, phase_next;
    logic [2:0]       method_pos_reg, method_pos_next;
    logic [1:0]       cand_reg, cand_next;
    logic [RAW_W-1:0] raw_count_reg, raw_count_next;
    logic [1:0]       stage_reg, stage_next;
    logic [7:0]       held_reg, held_next;
    logic [1:0]       emitted_reg, emitted_next;
    logic             slash_reg, slash_next;
    logic             cut_reg, cut_next;
    logic             head_reg, head_next;

    rlpd_cmd_t  c;
    logic       do_plain;
    logic [1:0] cand;
    logic [7:0] dec_val;
    logic [2:0] em_sum;
    logic [1:0] em_flush;

    always_comb
    begin
        phase_next      = phase_reg;
        method_pos_next = method_pos_reg;
        cand_next       = cand_reg;
        raw_count_next  = raw_count_reg;
        stage_next      = stage_reg;
        held_next       = held_reg;
        slash_next      = slash_reg;
        cut_next        = cut_reg;
        head_next       = head_reg;
        c               = '0;
        do_plain        = 1'b0;
        cand            = cand_reg;
        dec_val         = {hex_val(held_reg), hex_val(in_byte)};
        em_sum          = 3'd0;
        em_flush        = 2'd0;

        if (phase_reg != PH_DONE && in_byte == 8'h00)
        begin
            if (phase_reg == PH_METHOD)
            begin
                c.status_en = 1'b1;
                c.status    = ST_BAD_METHOD;
            end
            else
            begin
                c.status_en = 1'b1;
                c.status    = ST_NO_SPACE;
            end
            phase_next = PH_DONE;
        end
        else if (phase_reg == PH_METHOD)
        begin
            if (method_pos_reg >= 3'd4 || get_char(method_pos_reg[1:0]) != in_byte)
                cand[0] = 1'b0;
            if (method_pos_reg >= 3'd5 || head_char(method_pos_reg) != in_byte)
                cand[1] = 1'b0;
            cand_next = cand;
            if (cand == 2'b00)
            begin
                c.status_en = 1'b1;
                c.status    = ST_BAD_METHOD;
                phase_next  = PH_DONE;
            end
            else if (cand[0] && method_pos_reg == 3'd3)
            begin
                head_next  = 1'b0;
                phase_next = PH_PATH;
            end
            else if (cand[1] && method_pos_reg == 3'd4)
            begin
                head_next  = 1'b1;
                phase_next = PH_PATH;
            end
            else
            begin
                method_pos_next = method_pos_reg + 3'd1;
            end
        end
        else if (phase_reg == PH_PATH)
        begin
            if (in_byte == CH_SPACE)
            begin
                // Flush a pending escape literally, then complete a bare root.
                if (stage_reg == 2'd1)
                begin
                    c.bytes[0] = CH_PERCENT;
                    c.n_bytes  = 2'd1;
                end
                else if (stage_reg == 2'd2)
                begin
                    c.bytes[0] = CH_PERCENT;
                    c.bytes[1] = held_reg;
                    c.n_bytes  = 2'd2;
                end
                stage_next = 2'd0;
                em_sum     = {1'b0, emitted_reg} + {1'b0, c.n_bytes};
                em_flush   = (em_sum > 3'd2) ? 2'd2 : em_sum[1:0];
                c.index_tail = (em_flush == 2'd1) && slash_reg;
                c.status_en  = 1'b1;
                c.status     = ST_OK;
                phase_next   = PH_DONE;
            end
            else if (!cut_reg)
            begin
                if (raw_count_reg >= RAW_LIMIT)
                begin
                    cut_next = 1'b1;
                end
                else
                begin
                    raw_count_next = raw_count_reg + 1'b1;
                    if (stage_reg == 2'd1)
                    begin
                        if (is_hex(in_byte))
                        begin
                            held_next  = in_byte;
                            stage_next = 2'd2;
                        end
                        else
                        begin
                            c.bytes[0] = CH_PERCENT;
                            c.n_bytes  = 2'd1;
                            stage_next = 2'd0;
                            do_plain   = 1'b1;
                        end
                    end
                    else if (stage_reg == 2'd2)
                    begin
                        stage_next = 2'd0;
                        if (is_hex(in_byte))
                        begin
                            if (dec_val == 8'h00)
                            begin
                                cut_next = 1'b1;
                            end
                            else
                            begin
                                c.bytes[0] = dec_val;
                                c.n_bytes  = 2'd1;
                            end
                        end
                        else
                        begin
                            c.bytes[0] = CH_PERCENT;
                            c.bytes[1] = held_reg;
                            c.n_bytes  = 2'd2;
                            do_plain   = 1'b1;
                        end
                    end
                    else
                    begin
                        do_plain = 1'b1;
                    end

                    if (do_plain)
                    begin
                        if (in_byte == CH_PERCENT)
                        begin
                            stage_next = 2'd1;
                        end
                        else
                        begin
                            c.bytes[c.n_bytes] = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
                            c.n_bytes          = c.n_bytes + 2'd1;
                        end
                    end
                end
            end
        end

        // Track how many path bytes went out, saturating at two.
        em_sum = {1'b0, emitted_reg} + {1'b0, c.n_bytes};
        if (c.index_tail || em_sum > 3'd2)
            emitted_next = 2'd2;
        else
            emitted_next = em_sum[1:0];
        if (emitted_reg == 2'd0 && c.n_bytes != 2'd0 && c.bytes[0] == CH_SLASH)
            slash_next = 1'b1;

        c.hd = head_next;

        if (in_end)
        begin
            if (phase_next == PH_METHOD)
            begin
                c.status_en = 1'b1;
                c.status    = ST_BAD_METHOD;
            end
            else if (phase_next == PH_PATH)
            begin
                c.status_en = 1'b1;
                c.status    = ST_NO_SPACE;
            end
            phase_next      = PH_METHOD;
            method_pos_next = 3'd0;
            cand_next       = 2'b11;
            raw_count_next  = '0;
            stage_next      = 2'd0;
            held_next       = 8'h00;
            emitted_next    = 2'd0;
            slash_next      = 1'b0;
            cut_next        = 1'b0;
            head_next       = 1'b0;
        end
    end

    assign cmd  = c;
    assign push = accept && (c.n_bytes != 2'd0 || c.status_en);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_METHOD;
            method_pos_reg <= 3'd0;
            cand_reg       <= 2'b11;
            raw_count_reg  <= '0;
            stage_reg      <= 2'd0;
            held_reg       <= 8'h00;
            emitted_reg    <= 2'd0;
            slash_reg      <= 1'b0;
            cut_reg        <= 1'b0;
            head_reg       <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            method_pos_reg <= method_pos_next;
            cand_reg       <= cand_next;
            raw_count_reg  <= raw_count_next;
            stage_reg      <= stage_next;
            held_reg       <= held_next;
            emitted_reg    <= emitted_next;
            slash_reg      <= slash_next;
            cut_reg        <= cut_next;
            head_reg       <= head_next;
        end
    end

endmodule

@@ rtl/rlpd_queue.sv @@
// Short queue of result descriptors between the front and back parts.
`timescale 1ns / 1ps
`include "request_line_path_decoder_macros.svh"

module rlpd_queue
    import rlpd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  rlpd_cmd_t push_data,
    input  logic      pop,
    output rlpd_cmd_t head,
    output logic      empty,
    output logic      full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    rlpd_cmd_t        entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == FULL_CNT);
    assign head  = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `RLPD_ASSERT_SAME(a_no_overflow, clk, rst_n, push, !full, "push into a full queue")
    `RLPD_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count did not grow on push")

endmodule

@@ rtl/rlpd_back.sv @@
// Back part: expands descriptors into result items, one per unstalled cycle.
`timescale 1ns / 1ps
`include "request_line_path_decoder_macros.svh"

module rlpd_back
    import rlpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  rlpd_cmd_t  head,
    input  logic       q_empty,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic [7:0] out_byte,
    output logic [1:0] status,
    output logic       is_head,
    output logic       run_end
);

    logic [3:0] pos_reg, pos_next;
    logic       valid_reg, valid_next;
    logic       kind_reg;
    logic [7:0] byte_reg;
    logic [1:0] status_reg;
    logic       head_reg;
    logic       last_reg;

    logic [3:0] n_ext;
    logic [3:0] total;
    logic [3:0] tail_pos;
    logic       load;
    logic       last;
    logic       item_kind;
    logic [7:0] item_byte;
    logic [1:0] item_status;

    assign n_ext    = {2'b00, head.n_bytes};
    assign total    = n_ext + (head.index_tail ? INDEX_TAIL_LEN : 4'd0)
                    + {3'b000, head.status_en};
    assign tail_pos = pos_reg - n_ext;
    assign last     = (pos_reg == total - 4'd1);
    assign load     = !q_empty && (!valid_reg || !out_stall);
    assign pop      = load && last;

    always_comb
    begin
        item_kind   = 1'b0;
        item_byte   = 8'h00;
        item_status = ST_OK;
        if (pos_reg < n_ext)
            item_byte = head.bytes[pos_reg[1:0]];
        else if (head.index_tail && tail_pos < INDEX_TAIL_LEN)
            item_byte = index_char(tail_pos);
        else
        begin
            item_kind   = 1'b1;
            item_status = head.status;
        end
    end

    always_comb
    begin
        pos_next   = pos_reg;
        valid_next = valid_reg;
        if (load)
        begin
            pos_next   = last ? 4'd0 : pos_reg + 4'd1;
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= item_kind;
            byte_reg   <= item_byte;
            status_reg <= item_status;
            head_reg   <= head.hd;
            last_reg   <= last;
        end
    end

    assign out_valid = valid_reg;
    assign kind      = kind_reg;
    assign out_byte  = byte_reg;
    assign status    = status_reg;
    assign is_head   = head_reg;
    assign run_end   = last_reg;

    `RLPD_ASSERT_SAME(a_pos_in_range, clk, rst_n, !q_empty, pos_reg < total, "item position beyond descriptor")
    `RLPD_ASSERT_SAME(a_status_is_last, clk, rst_n, load && item_kind, last, "status item is not the last result")
    `RLPD_ASSERT_NEXT(a_pos_restart, clk, rst_n, pop, pos_reg == 4'd0, "position did not restart after pop")

endmodule

@@ rtl/request_line_path_decoder.sv @@
// Top level of the request line path decoder.
// Input channel: one request byte per request (in_byte, in_end) under
// in_valid / in_stall; a request is taken at an edge with in_valid high and
// in_stall low. Output channel: result items (kind, out_byte, status,
// is_head, run_end) under out_valid / out_stall, held steady while stalled.
// The front part matches GET or HEAD, percent-decodes the path and packs all
// results caused by one byte into a descriptor; the back part plays each
// descriptor out one result per unstalled cycle via a registered output stage.
// A byte's descriptor is written into the queue at the edge that takes the
// byte, and its first result is then loaded into the output register.
// Throughput: one byte per cycle while each byte causes at most one result
// and out_stall stays low; a byte causing N results holds the back part until
// all N are out (up to 11 for the "/index.html" completion), and the front
// keeps taking bytes until the QUEUE_DEPTH-entry descriptor queue fills,
// which raises in_stall. A stalled receiver holds the output register; the
// queue absorbs bytes until it is full. Reset clears the parser to method
// matching, empties the queue and drops out_valid; no clearing pass is needed.
`timescale 1ns / 1ps

module request_line_path_decoder
    import rlpd_pkg::*;
#(
    parameter int MAX_PATH_LEN = 256,
    parameter int QUEUE_DEPTH  = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic [7:0] out_byte,
    output logic [1:0] status,
    output logic       is_head,
    output logic       run_end
);

    logic      accept;
    logic      push;
    logic      pop;
    logic      q_empty;
    logic      q_full;
    rlpd_cmd_t push_cmd;
    rlpd_cmd_t head_cmd;

    // The front only stalls when the descriptor queue has no free entry.
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    rlpd_front #(
        .MAX_PATH_LEN (MAX_PATH_LEN)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .in_end  (in_end),
        .push    (push),
        .cmd     (push_cmd)
    );

    rlpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .head      (head_cmd),
        .empty     (q_empty),
        .full      (q_full)
    );

    rlpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head_cmd),
        .q_empty   (q_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .out_byte  (out_byte),
        .status    (status),
        .is_head   (is_head),
        .run_end   (run_end)
    );

endmodule
